/* hdl/fpat_pkg.sv */
// ----------------------------------------------------------------------------
// fpat_pkg
// Shared constants, the tangent table and the sideband type of the atan2 block.
// ----------------------------------------------------------------------------
package fpat_pkg;

  localparam int TABLE_ENTRIES = 360;
  localparam int FRAC_BITS     = 14;
  localparam int DATA_W        = 32;
  localparam int ANGLE_W       = 11;
  localparam int QUOT_W        = DATA_W - 1;
  localparam int NUM_W         = DATA_W + FRAC_BITS;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int PTR_W         = IDX_W + 1;
  localparam int ROM_AW        = $clog2(TABLE_ENTRIES);
  localparam int SEARCH_STEPS  = $clog2(TABLE_ENTRIES + 1);
  localparam int FOLD_W        = ANGLE_W + 2;

  localparam logic [ANGLE_W-1:0] ANG_ZERO          = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] ANG_QUARTER       = ANGLE_W'(360);
  localparam logic [ANGLE_W-1:0] ANG_HALF          = ANGLE_W'(720);
  localparam logic [ANGLE_W-1:0] ANG_THREE_QUARTER = ANGLE_W'(1080);
  localparam int                 ANG_TURN          = 1440;

  typedef logic [DATA_W-1:0] rom_t [TABLE_ENTRIES];

  typedef struct packed {
    logic               special;
    logic [ANGLE_W-1:0] special_angle;
    logic               x_neg;
    logic               y_neg;
  } side_t;

  function automatic rom_t build_rom();
    rom_t r;
    real  a;
    real  t;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      a = (i * 2.0 * 3.141592654) / 1440.0;
      t = $tan(a) * (2.0 ** FRAC_BITS);
      if (t >= 2147483647.0) begin
        r[i] = 32'h7fff_ffff;
      end else begin
        r[i] = DATA_W'($rtoi(t));
      end
    end
    return r;
  endfunction

  localparam rom_t TAN_ROM = build_rom();

endpackage

/* hdl/fpat_div.sv */
// ----------------------------------------------------------------------------
// fpat_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module fpat_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  fpat_pkg::side_t               in_side,
  input  logic [fpat_pkg::NUM_W-1:0]    num,
  input  logic [fpat_pkg::DATA_W-1:0]   den,
  output logic                          out_valid,
  output fpat_pkg::side_t               out_side,
  output logic [fpat_pkg::QUOT_W-1:0]   quot
);
  import fpat_pkg::*;

  logic                vld  [QUOT_W+1];
  side_t               side [QUOT_W+1];
  logic [NUM_W-1:0]    nums [QUOT_W+1];
  logic [DATA_W-1:0]   dens [QUOT_W+1];
  logic [DATA_W-1:0]   rem  [QUOT_W+1];
  logic [QUOT_W-1:0]   q    [QUOT_W+1];
  logic                sat  [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      side[0] <= in_side;
      nums[0] <= num;
      dens[0] <= den;
      rem[0]  <= DATA_W'(num[NUM_W-1:QUOT_W]);
      sat[0]  <= DATA_W'(num[NUM_W-1:QUOT_W]) >= den;
      q[0]    <= '0;
    end
  end

  for (genvar s = 1; s <= QUOT_W; s++) begin : g_stage
    logic [DATA_W:0] trial;
    logic            ge;
    assign trial = {rem[s-1], nums[s-1][QUOT_W-s]};
    assign ge    = trial >= {1'b0, dens[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
      if (en) begin
        side[s] <= side[s-1];
        nums[s] <= nums[s-1];
        dens[s] <= dens[s-1];
        sat[s]  <= sat[s-1];
        rem[s]  <= ge ? DATA_W'(trial - {1'b0, dens[s-1]}) : DATA_W'(trial);
        q[s]    <= {q[s-1][QUOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = vld[QUOT_W];
  assign out_side  = side[QUOT_W];
  assign quot      = sat[QUOT_W] ? {QUOT_W{1'b1}} : q[QUOT_W];

endmodule

/* hdl/fpat_search.sv */
// ----------------------------------------------------------------------------
// fpat_search
// Pipelined binary search of the tangent table, one probe per stage.
// ----------------------------------------------------------------------------
module fpat_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  fpat_pkg::side_t              in_side,
  input  logic [fpat_pkg::QUOT_W-1:0]  t,
  output logic                         out_valid,
  output fpat_pkg::side_t              out_side,
  output logic [fpat_pkg::IDX_W-1:0]   index
);
  import fpat_pkg::*;

  // Each stage registers the next probe index and the table entry read at it.
  logic                    vld   [SEARCH_STEPS+1];
  side_t                   side  [SEARCH_STEPS+1];
  logic [QUOT_W-1:0]       tv    [SEARCH_STEPS+1];
  logic signed [PTR_W-1:0] low   [SEARCH_STEPS+1];
  logic signed [PTR_W-1:0] high  [SEARCH_STEPS+1];
  logic signed [PTR_W-1:0] mid   [SEARCH_STEPS+1];
  logic [DATA_W-1:0]       entry [SEARCH_STEPS+1];
  logic                    done  [SEARCH_STEPS+1];
  logic [IDX_W-1:0]        res   [SEARCH_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      side[0]  <= in_side;
      tv[0]    <= t;
      low[0]   <= '0;
      high[0]  <= PTR_W'(TABLE_ENTRIES - 1);
      mid[0]   <= PTR_W'((TABLE_ENTRIES - 1) / 2);
      entry[0] <= TAN_ROM[(TABLE_ENTRIES - 1) / 2];
      done[0]  <= 1'b0;
      res[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= SEARCH_STEPS; s++) begin : g_step
    logic [DATA_W-1:0]       tw;
    logic                    lt;
    logic                    gt;
    logic signed [PTR_W-1:0] low_next;
    logic signed [PTR_W-1:0] high_next;
    logic signed [PTR_W:0]   sum;
    logic signed [PTR_W-1:0] mid_next;
    logic [ROM_AW-1:0]       rom_addr;
    logic [IDX_W-1:0]        miss;

    assign tw        = DATA_W'(tv[s-1]);
    assign lt        = tw < entry[s-1];
    assign gt        = tw > entry[s-1];
    assign low_next  = gt ? mid[s-1] + PTR_W'(1) : low[s-1];
    assign high_next = lt ? mid[s-1] - PTR_W'(1) : high[s-1];
    assign sum       = (PTR_W+1)'(low_next) + (PTR_W+1)'(high_next);
    assign mid_next  = PTR_W'(sum >>> 1);
    assign rom_addr  = (mid_next >= 0 && mid_next < PTR_W'(TABLE_ENTRIES))
                       ? ROM_AW'(mid_next) : '0;

    always_comb begin
      miss = IDX_W'(mid[s-1]);
      if (lt && mid[s-1] == PTR_W'(1)) begin
        miss = '0;
      end else if (gt && mid[s-1] == PTR_W'(TABLE_ENTRIES - 1)) begin
        miss = IDX_W'(TABLE_ENTRIES);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
      if (en) begin
        side[s]  <= side[s-1];
        tv[s]    <= tv[s-1];
        low[s]   <= low_next;
        high[s]  <= high_next;
        mid[s]   <= mid_next;
        entry[s] <= TAN_ROM[rom_addr];
        if (done[s-1]) begin
          done[s] <= 1'b1;
          res[s]  <= res[s-1];
        end else if (!lt && !gt) begin
          done[s] <= 1'b1;
          res[s]  <= IDX_W'(mid[s-1]);
        end else if (low_next > high_next) begin
          done[s] <= 1'b1;
          res[s]  <= miss;
        end else begin
          done[s] <= 1'b0;
          res[s]  <= res[s-1];
        end
      end
    end
  end

  assign out_valid = vld[SEARCH_STEPS];
  assign out_side  = side[SEARCH_STEPS];
  assign index     = res[SEARCH_STEPS];

endmodule

/* hdl/fixed_point_atan2_table_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_atan2_table_top
// Fixed-point atan2 with 1440 angle steps per turn.
//
// A beat on the slave side carries x and y, signed with 14 fraction bits.
// The block forms the tangent ratio in a 31-stage divider pipeline, then
// searches the 360-entry tangent table with one probe per stage over nine
// stages, and folds the index into a quadrant. Axis cases bypass the
// search and travel alongside the data.
// Unless stalled, one beat is accepted per cycle; all stages advance together.
// When the receiver stalls with a result waiting, the pipeline freezes and
// s_axis_tready falls in the same cycle; no beat is lost or repeated.
// Reset clears all valid bits; the tangent table is constant.
// ----------------------------------------------------------------------------
module fixed_point_atan2_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_value [31:0], y_value [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // angle [10:0], zero [15:11]
);
  import fpat_pkg::*;

  logic                    en;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] y;
  logic [DATA_W-1:0]       abs_x;
  logic [DATA_W-1:0]       abs_y;
  side_t                   side_in;

  logic                    in_vld;
  side_t                   in_side;
  logic [NUM_W-1:0]        in_num;
  logic [DATA_W-1:0]       in_den;

  logic                    div_vld;
  side_t                   div_side;
  logic [QUOT_W-1:0]       div_q;

  logic                    srch_vld;
  side_t                   srch_side;
  logic [IDX_W-1:0]        srch_idx;

  logic signed [FOLD_W-1:0] fold;
  logic signed [FOLD_W-1:0] wrapped;
  logic                     out_vld;
  logic [ANGLE_W-1:0]       angle;

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  assign x     = s_axis_tdata[31:0];
  assign y     = s_axis_tdata[63:32];
  assign abs_x = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  assign abs_y = y[DATA_W-1] ? DATA_W'(-y) : DATA_W'(y);

  always_comb begin
    side_in.x_neg         = x[DATA_W-1];
    side_in.y_neg         = y[DATA_W-1];
    side_in.special       = (y == '0) || (x == '0);
    side_in.special_angle = ANG_ZERO;
    if (y == '0) begin
      side_in.special_angle = x[DATA_W-1] ? ANG_HALF : ANG_ZERO;
    end else if (x == '0) begin
      side_in.special_angle = y[DATA_W-1] ? ANG_THREE_QUARTER : ANG_QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_axis_tvalid;
    end
    if (en) begin
      in_side <= side_in;
      in_num  <= {abs_x, {FRAC_BITS{1'b0}}};
      in_den  <= abs_y;
    end
  end

  fpat_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_vld),
    .in_side   (in_side),
    .num       (in_num),
    .den       (in_den),
    .out_valid (div_vld),
    .out_side  (div_side),
    .quot      (div_q)
  );

  fpat_search u_search (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_vld),
    .in_side   (div_side),
    .t         (div_q),
    .out_valid (srch_vld),
    .out_side  (srch_side),
    .index     (srch_idx)
  );

  always_comb begin
    case ({srch_side.x_neg, srch_side.y_neg})
      2'b00:   fold = FOLD_W'(ANG_QUARTER) - FOLD_W'(srch_idx);
      2'b01:   fold = (srch_idx == IDX_W'(ANG_QUARTER)) ? '0
                      : FOLD_W'(ANG_THREE_QUARTER) + FOLD_W'(srch_idx);
      2'b10:   fold = FOLD_W'(ANG_QUARTER) + FOLD_W'(srch_idx);
      default: fold = FOLD_W'(ANG_THREE_QUARTER) - FOLD_W'(srch_idx);
    endcase
    if (fold < 0) begin
      wrapped = fold + FOLD_W'(ANG_TURN);
    end else if (fold >= FOLD_W'(ANG_TURN)) begin
      wrapped = fold - FOLD_W'(ANG_TURN);
    end else begin
      wrapped = fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= srch_vld;
    end
    if (en) begin
      angle <= srch_side.special ? srch_side.special_angle : ANGLE_W'(wrapped);
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'b0, angle};

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point atan2 table block.
//
// Coordinate beats go in on the slave stream; every accepted beat gets an
// angle, fixed in the table for axis rows and otherwise predicted from an
// exactly built tangent table, a binary search over it and the quadrant
// fold. Angles coming out on the master stream are compared in order against
// the queue of expected angles. A short table of axis, extreme and saturating
// cases runs first, then random coordinates with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpat_pkg::*;

  localparam int N_RANDOM = 1330;
  localparam int QUIET_FROM = 1150;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 known;
    logic [10:0]        angle;
  } coord_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  logic [63:0]  tan_table [TABLE_ENTRIES];
  logic [10:0]  angle_queue [$];
  int           errors = 0;
  bit           quiet = 1'b0;
  bit           stim_done = 1'b0;

  fixed_point_atan2_table_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Tangent in Q(FRAC_BITS) from Q60 sine and cosine series, truncated.
  function automatic logic [63:0] tangent_entry(int unsigned i);
    logic [63:0] pi_q60, excess, step, srem, r, r2, st, s, ct, c, mag, rem;
    pi_q60 = 64'h3243F6A8885A308D;
    excess = 64'd472936197;
    step = pi_q60 / 720;
    srem = pi_q60 % 720;
    r = 64'(i) * step + (64'(i) * srem + 64'(i) * excess) / 720;
    r2 = mul_q60(r, r);
    st = r;
    s = r;
    ct = 64'd1 << 60;
    c = 64'd1 << 60;
    for (int n = 1; n <= 16; n++) begin
      st = mul_q60(st, r2) / 64'((2 * n) * (2 * n + 1));
      ct = mul_q60(ct, r2) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s -= st;
        c -= ct;
      end else begin
        s += st;
        c += ct;
      end
    end
    if (c == 0 || s / c >= (64'd1 << (31 - FRAC_BITS))) return 64'h7fff_ffff;
    mag = s / c;
    rem = s % c;
    for (int b = 0; b < FRAC_BITS; b++) begin
      rem = rem << 1;
      mag = mag << 1;
      if (rem >= c) begin
        rem -= c;
        mag[0] = 1'b1;
      end
    end
    return mag;
  endfunction

  function automatic int table_search(longint t);
    int lo, hi, mid;
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    forever begin
      mid = (lo + hi) >>> 1;
      if (t < longint'(tan_table[mid])) hi = mid - 1;
      else if (t > longint'(tan_table[mid])) lo = mid + 1;
      else return mid;
      if (lo > hi) begin
        if (mid == 1) begin
          if (t < longint'(tan_table[1])) mid = 0;
        end else if (mid == TABLE_ENTRIES - 1) begin
          if (t > longint'(tan_table[TABLE_ENTRIES - 1])) mid = TABLE_ENTRIES;
        end
        return mid;
      end
    end
  endfunction

  function automatic logic [10:0] predict_angle(logic signed [31:0] xv,
                                                logic signed [31:0] yv);
    longint x, y, q, t, ang;
    int v;
    x = xv;
    y = yv;
    if (y == 0) return (x >= 0) ? ANG_ZERO : ANG_HALF;
    if (x == 0) return (y > 0) ? ANG_QUARTER : ANG_THREE_QUARTER;
    q = (x * (64'sd1 <<< FRAC_BITS)) / y;
    t = (q < 0) ? -q : q;
    if (t > 64'sh7fff_ffff) t = 64'sh7fff_ffff;
    v = table_search(t);
    if (x > 0) begin
      if (y > 0) ang = 360 - v;
      else if (v == 360) ang = 0;
      else ang = 1080 + v;
    end else begin
      if (y > 0) ang = 360 + v;
      else ang = 1080 - v;
    end
    ang = ang % ANG_TURN;
    if (ang < 0) ang += ANG_TURN;
    return 11'(ang);
  endfunction

  task automatic send_coord(logic signed [31:0] x, logic signed [31:0] y,
                            bit known, logic [10:0] angle);
    int gap;
    s_axis_tdata <= {y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    angle_queue.push_back(known ? angle : predict_angle(x, y));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sd0;
      1, 2:    return 32'($urandom);
      3:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      4, 5:    return 32'($signed(20'($urandom)));
      default: return 32'($signed(12'($urandom))) <<< $urandom_range(0, 16);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (angle_queue.size() == 0) begin
        $error("unexpected beat: angle %0d", m_axis_tdata[10:0]);
        errors++;
      end else begin
        if (m_axis_tdata[10:0] !== angle_queue[0]) begin
          $error("angle: expected %0d, actual %0d", angle_queue[0], m_axis_tdata[10:0]);
          errors++;
        end
        if (m_axis_tdata[15:11] !== 5'd0) begin
          $error("zero: expected 0, actual %0h", m_axis_tdata[15:11]);
          errors++;
        end
        void'(angle_queue.pop_front());
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet || stim_done) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    coord_row_t rows [$];
    rows = '{
      '{32'sd0, 32'sd0, 1, ANG_ZERO},
      '{32'sd5, 32'sd0, 1, ANG_ZERO},
      '{-32'sd5, 32'sd0, 1, ANG_HALF},
      '{32'sh7fff_ffff, 32'sd0, 1, ANG_ZERO},
      '{32'sh8000_0000, 32'sd0, 1, ANG_HALF},
      '{32'sd0, 32'sd5, 1, ANG_QUARTER},
      '{32'sd0, -32'sd5, 1, ANG_THREE_QUARTER},
      '{32'sd0, 32'sh7fff_ffff, 1, ANG_QUARTER},
      '{32'sd0, 32'sh8000_0000, 1, ANG_THREE_QUARTER},
      '{32'sd16384, 32'sd16384, 0, '0},
      '{32'sd16384, -32'sd16384, 0, '0},
      '{-32'sd16384, 32'sd16384, 0, '0},
      '{-32'sd16384, -32'sd16384, 0, '0},
      '{32'sh8000_0000, 32'sh8000_0000, 0, '0},
      '{32'sh7fff_ffff, 32'sd1, 0, '0},
      '{32'sh8000_0000, -32'sd1, 0, '0},
      '{32'sh7fff_ffff, -32'sd1, 0, '0},
      '{32'sh8000_0000, 32'sd1, 0, '0},
      '{32'sd1, 32'sh7fff_ffff, 0, '0},
      '{-32'sd1, 32'sh8000_0000, 0, '0},
      '{32'sd3, 32'sd1000, 0, '0},
      '{32'sd1000, 32'sd3, 0, '0},
      '{-32'sd7, 32'sd2, 0, '0}
    };
    for (int i = 0; i < TABLE_ENTRIES; i++) tan_table[i] = tangent_entry(i);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_coord(rows[i].x, rows[i].y, rows[i].known, rows[i].angle);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        s_axis_tvalid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge clk);
      end
      if (n == QUIET_FROM) quiet = 1'b1;
      send_coord(random_coord(), random_coord(), 0, '0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
